/* rtl/hsvrgb_pkg.sv */
// Shared types and constants for the HSV to RGB color converter.
package hsvrgb_pkg;

   // Pipeline depth from an accepted transaction to a valid result.
   localparam int NUM_STAGES = 7;

   // Hue geometry in 1/64 degree units.
   localparam logic [15:0] HUE_FULL_TURN = 16'd23040;
   localparam logic [15:0] HUE_TWO_TURNS = 16'd46080;
   localparam logic [14:0] HUE_SECTOR    = 15'd3840;

   // Saturation and value are fractions of this full scale.
   localparam logic [7:0]  FRAC_MAX = 8'd255;

   // Common denominator of the q and t terms, 255 * 3840.
   localparam logic [19:0] QT_DENOM = 20'd979200;

   // Ceiling of 2^32 / 3825; exact quotient for any dividend below 2^20.
   localparam logic [20:0] QT_RECIP = 21'd1122868;

   // Input transaction.
   typedef struct packed {
      logic [15:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness_value;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Per-stage load enables from the pipeline control.
   typedef logic [NUM_STAGES-1:0] stage_vec_type;

   // Hue split into sector and fraction, with the saturation, value and v*(255-s).
   typedef struct packed {
      logic [2:0]  sector;
      logic [11:0] frac;
      logic [7:0]  sat;
      logic [7:0]  val;
      logic [15:0] pprod;
   } hue_split_type;

   // Finished terms ready for the sector selection.
   typedef struct packed {
      logic [2:0] sector;
      logic [7:0] sat;
      logic [7:0] val;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
   } terms_type;

endpackage

/* rtl/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB color converter.
//
// The request channel (req_valid, req_stall, req_data) takes one hue,
// saturation and value triple per transaction; hue is in 1/64 degree units
// and wraps at 360 degrees. The response channel (rsp_valid, rsp_stall,
// rsp_data) returns one 8-bit red, green and blue triple per transaction,
// in order. A transaction moves when valid is high and stall is low.
// The block takes a new transaction every cycle while req_stall is low;
// it is a seven-stage pipeline whose widest step is one 20 by 21 bit
// multiply. Stages that are empty or moving keep accepting while a finished
// result waits, so bubbles close up.
// When the receiver stalls, the pipeline fills and req_stall rises only
// once every stage holds a transaction; nothing is dropped or repeated.
// Reset clears all valid bits; no other state is kept between transactions.
module hsv_to_rgb_converter
   import hsvrgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   stage_vec_type stage_en;
   hue_split_type split;
   terms_type     terms;

   // Pipeline control.
   hsvrgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .stage_en  (stage_en)
   );

   // Hue wrap and sector split.
   hsvrgb_hue u_hue (
      .clock    (clock),
      .stage_en (stage_en[1:0]),
      .req_data (req_data),
      .split    (split)
   );

   // Term arithmetic.
   hsvrgb_scale u_scale (
      .clock    (clock),
      .stage_en (stage_en[5:2]),
      .split    (split),
      .terms    (terms)
   );

   // Output selection and register.
   hsvrgb_mux u_mux (
      .clock    (clock),
      .stage_en (stage_en[6]),
      .terms    (terms),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/hsvrgb_ctrl.sv */
// Valid and stall control for the converter pipeline.
module hsvrgb_ctrl
   import hsvrgb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_stall,
   output logic          req_stall,
   output logic          rsp_valid,
   output stage_vec_type stage_en
);

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type ready;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   // Valid bits travel with the data; a stage that holds keeps its bit.
   always_comb begin
      if (ready[0]) begin
         valid_in[0] = req_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (ready[i]) begin
            valid_in[i] = valid_ff[i-1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign stage_en  = ready;
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

endmodule

/* rtl/hsvrgb_hue.sv */
// Hue reduction and sector split, pipeline stages one and two.
module hsvrgb_hue
   import hsvrgb_pkg::*;
(
   input  logic          clock,
   input  logic [1:0]    stage_en,
   input  req_type       req_data,
   output hue_split_type split
);

   logic [14:0]   hr_ff;
   logic [14:0]   hr_in;
   logic [7:0]    sat_ff;
   logic [7:0]    val_ff;
   logic [15:0]   pprod_ff;
   logic [15:0]   pprod_in;
   logic [15:0]   hue_diff;
   hue_split_type split_ff;
   hue_split_type split_in;
   logic [2:0]    sector;
   logic [14:0]   sector_base;

   // The hue field spans less than three turns, so two compares wrap it.
   always_comb begin
      if (req_data.hue >= HUE_TWO_TURNS) begin
         hue_diff = req_data.hue - HUE_TWO_TURNS;
      end else if (req_data.hue >= HUE_FULL_TURN) begin
         hue_diff = req_data.hue - HUE_FULL_TURN;
      end else begin
         hue_diff = req_data.hue;
      end
      hr_in    = hue_diff[14:0];
      pprod_in = 16'(req_data.brightness_value) * 16'(FRAC_MAX - req_data.saturation);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         hr_ff    <= hr_in;
         sat_ff   <= req_data.saturation;
         val_ff   <= req_data.brightness_value;
         pprod_ff <= pprod_in;
      end
   end

   // The sector is the count of sector boundaries at or below the hue.
   always_comb begin
      sector = 3'd0;
      for (int k = 1; k < 6; k++) begin
         if (hr_ff >= 15'(k * 3840)) begin
            sector = 3'(k);
         end
      end
   end

   // Remove the sector base to leave the fraction within the sector.
   always_comb begin
      case (sector)
         3'd1:    sector_base = HUE_SECTOR;
         3'd2:    sector_base = 15'(2 * 3840);
         3'd3:    sector_base = 15'(3 * 3840);
         3'd4:    sector_base = 15'(4 * 3840);
         3'd5:    sector_base = 15'(5 * 3840);
         default: sector_base = '0;
      endcase
      split_in.sector = sector;
      split_in.frac   = 12'(hr_ff - sector_base);
      split_in.sat    = sat_ff;
      split_in.val    = val_ff;
      split_in.pprod  = pprod_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;

endmodule

/* rtl/hsvrgb_scale.sv */
// Computation of the p, q and t terms, pipeline stages three to six.
module hsvrgb_scale
   import hsvrgb_pkg::*;
(
   input  logic          clock,
   input  logic [3:0]    stage_en,
   input  hue_split_type split,
   output terms_type     terms
);

   // Fields carried alongside the arithmetic.
   typedef struct packed {
      logic [2:0] sector;
      logic [7:0] sat;
      logic [7:0] val;
      logic [7:0] p;
   } carry_type;

   carry_type   c3_ff, c4_ff, c5_ff, c6_ff;
   carry_type   c3_in;
   logic [19:0] sf_ff;
   logic [19:0] sf_in;
   logic [19:0] nq_ff, nt_ff;
   logic [19:0] nq_in, nt_in;
   logic [27:0] xq_ff, xt_ff;
   logic [27:0] xq_in, xt_in;
   logic [40:0] mq_ff, mt_ff;
   logic [40:0] mq_in, mt_in;
   logic [19:0] s3840;
   logic [16:0] p_sum;
   logic [8:0]  p_est;
   logic [16:0] p_rem;

   // Stage three: s*f, and v*(255-s)/255 by estimate and one correction.
   always_comb begin
      sf_in = 20'(split.sat) * 20'(split.frac);
      p_sum = {1'b0, split.pprod} + {9'b0, split.pprod[15:8]};
      p_est = p_sum[16:8];
      p_rem = {1'b0, split.pprod} - (17'({p_est, 8'b0}) - 17'(p_est));
      c3_in.sector = split.sector;
      c3_in.sat    = split.sat;
      c3_in.val    = split.val;
      if (p_rem >= 17'(FRAC_MAX)) begin
         c3_in.p = 8'(p_est + 9'd1);
      end else begin
         c3_in.p = p_est[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sf_ff <= sf_in;
         c3_ff <= c3_in;
      end
   end

   // Stage four: numerators of q and t over the common denominator.
   always_comb begin
      s3840 = {c3_ff.sat, 12'b0} - {4'b0, c3_ff.sat, 8'b0};
      nq_in = QT_DENOM - sf_ff;
      nt_in = QT_DENOM - s3840 + sf_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         nq_ff <= nq_in;
         nt_ff <= nt_in;
         c4_ff <= c3_ff;
      end
   end

   // Stage five: scale the numerators by the value.
   always_comb begin
      xq_in = 28'(c4_ff.val) * 28'(nq_ff);
      xt_in = 28'(c4_ff.val) * 28'(nt_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         xq_ff <= xq_in;
         xt_ff <= xt_in;
         c5_ff <= c4_ff;
      end
   end

   // Stage six: divide by 979200 as a shift by 8 and a reciprocal of 3825.
   always_comb begin
      mq_in = 41'(xq_ff[27:8]) * 41'(QT_RECIP);
      mt_in = 41'(xt_ff[27:8]) * 41'(QT_RECIP);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         mq_ff <= mq_in;
         mt_ff <= mt_in;
         c6_ff <= c5_ff;
      end
   end

   always_comb begin
      terms.sector = c6_ff.sector;
      terms.sat    = c6_ff.sat;
      terms.val    = c6_ff.val;
      terms.p      = c6_ff.p;
      terms.q      = mq_ff[39:32];
      terms.t      = mt_ff[39:32];
   end

endmodule

/* rtl/hsvrgb_mux.sv */
// Sector selection of the terms into red, green and blue, final stage.
module hsvrgb_mux
   import hsvrgb_pkg::*;
(
   input  logic      clock,
   input  logic      stage_en,
   input  terms_type terms,
   output rsp_type   rsp_data
);

   rsp_type rsp_ff;
   rsp_type rsp_in;

   // Zero saturation gives grey; otherwise the standard HSV sector table.
   always_comb begin
      if (terms.sat == 8'd0) begin
         rsp_in = '{red: terms.val, green: terms.val, blue: terms.val};
      end else begin
         case (terms.sector)
            3'd0:    rsp_in = '{red: terms.val, green: terms.t,   blue: terms.p};
            3'd1:    rsp_in = '{red: terms.q,   green: terms.val, blue: terms.p};
            3'd2:    rsp_in = '{red: terms.p,   green: terms.val, blue: terms.t};
            3'd3:    rsp_in = '{red: terms.p,   green: terms.q,   blue: terms.val};
            3'd4:    rsp_in = '{red: terms.t,   green: terms.p,   blue: terms.val};
            default: rsp_in = '{red: terms.val, green: terms.p,   blue: terms.q};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* sim/hsv_to_rgb_converter_test.sv */
// Self-checking testbench for the HSV to RGB color converter.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;
   import hsvrgb_pkg::*;

   // Six 60-degree hue sectors, in the order the hue angle sweeps them.
   typedef enum int {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

   localparam int RANDOM_ITEMS = 2000;
   localparam int MID_DRAIN    = 1000;
   localparam int STEADY_FIRST = 1200;
   localparam int STEADY_LAST  = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_hsv[$];
   rsp_type expected_rgb[$];
   int      accepted_count = 0;
   int      received_count = 0;
   int      directed_count = 0;
   int      error_count = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   int      open_left = 0;
   rsp_type oldest_rgb;

   hsv_to_rgb_converter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Computes the color one HSV transaction must produce; terms are floored.
   function automatic rsp_type hsv_color(req_type item);
      longint     v;
      longint     s;
      longint     reduced;
      longint     frac;
      longint     p;
      longint     q;
      longint     t;
      sector_type sector;
      rsp_type    color;
      v = item.brightness_value;
      s = item.saturation;
      reduced = longint'(item.hue) % longint'(HUE_FULL_TURN);
      sector = sector_type'(int'(reduced / longint'(HUE_SECTOR)));
      frac = reduced % longint'(HUE_SECTOR);
      p = v * (longint'(FRAC_MAX) - s) / longint'(FRAC_MAX);
      q = v * (longint'(QT_DENOM) - s * frac) / longint'(QT_DENOM);
      t = v * (longint'(QT_DENOM) - s * (longint'(HUE_SECTOR) - frac))
          / longint'(QT_DENOM);
      if (s == 0) begin
         color = '{red: v[7:0], green: v[7:0], blue: v[7:0]};
      end else begin
         case (sector)
            SEC_RED_YELLOW:   color = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
            SEC_YELLOW_GREEN: color = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
            SEC_GREEN_CYAN:   color = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
            SEC_CYAN_BLUE:    color = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
            SEC_BLUE_MAGENTA: color = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
            default:          color = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
         endcase
      end
      return color;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_error(string what, int got, int want);
      error_count++;
      $display("ERROR at %0t: result %0d %s: got %0d, expected %0d",
               $realtime, received_count, what, got, want);
   endtask

   function automatic req_type hsv_item(int hue, int sat, int val);
      req_type item;
      item.hue = hue[15:0];
      item.saturation = sat[7:0];
      item.brightness_value = val[7:0];
      return item;
   endfunction

   // Random transaction with extra weight on the saturation and value extremes.
   function automatic req_type random_hsv();
      req_type item;
      item.hue = 16'($urandom);
      case ($urandom_range(0, 7))
         0:       item.saturation = 8'd0;
         1:       item.saturation = 8'd255;
         default: item.saturation = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       item.brightness_value = 8'd0;
         1:       item.brightness_value = 8'd255;
         default: item.brightness_value = 8'($urandom);
      endcase
      return item;
   endfunction

   // Driver: presents queued transactions in bursts with random gaps, and
   // holds off at the drain points until every expected color has come back.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rgb.push_back(hsv_color(req_data));
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if ((accepted_count == directed_count || accepted_count == MID_DRAIN)
                         && expected_rgb.size() != 0) begin
               req_valid <= 1'b0;
            end else if (pending_hsv.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_hsv.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  if (accepted_count >= STEADY_FIRST && accepted_count <= STEADY_LAST)
                     gap_left = 0;
                  else if ($urandom_range(0, 3) == 0)
                     gap_left = 0;
                  else
                     gap_left = $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted color against the oldest expectation and
   // stalls the result channel in runs of its own.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb.size() == 0) begin
               report_error("arrived with nothing expected", int'(rsp_data), 0);
            end else begin
               oldest_rgb = expected_rgb.pop_front();
               if (rsp_data.red !== oldest_rgb.red)
                  report_error("red", int'(rsp_data.red), int'(oldest_rgb.red));
               if (rsp_data.green !== oldest_rgb.green)
                  report_error("green", int'(rsp_data.green), int'(oldest_rgb.green));
               if (rsp_data.blue !== oldest_rgb.blue)
                  report_error("blue", int'(rsp_data.blue), int'(oldest_rgb.blue));
            end
            received_count++;
         end
         if (received_count >= STEADY_FIRST && received_count <= STEADY_LAST) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (open_left > 0) begin
            open_left--;
            rsp_stall <= 1'b0;
         end else begin
            open_left = $urandom_range(0, 12);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                     : $urandom_range(0, 3);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int k;
      // Each sector at mid fraction, full saturation and value.
      for (k = 0; k < 6; k++)
         pending_hsv.push_back(hsv_item(k * 3840 + 1920, 255, 255));
      // Sector edges and hue wrap-around.
      pending_hsv.push_back(hsv_item(0, 255, 255));
      pending_hsv.push_back(hsv_item(3839, 255, 255));
      pending_hsv.push_back(hsv_item(3840, 200, 255));
      pending_hsv.push_back(hsv_item(23039, 255, 200));
      pending_hsv.push_back(hsv_item(23040, 255, 255));
      pending_hsv.push_back(hsv_item(46080, 128, 255));
      pending_hsv.push_back(hsv_item(65535, 255, 255));
      pending_hsv.push_back(hsv_item(19200, 1, 255));
      // Zero saturation gives grey at the value level.
      pending_hsv.push_back(hsv_item(5000, 0, 173));
      pending_hsv.push_back(hsv_item(65535, 0, 255));
      pending_hsv.push_back(hsv_item(12345, 0, 0));
      // Zero, small and near-full values.
      pending_hsv.push_back(hsv_item(9000, 255, 0));
      pending_hsv.push_back(hsv_item(17000, 255, 1));
      pending_hsv.push_back(hsv_item(32768, 77, 254));
      directed_count = pending_hsv.size();
      for (k = 0; k < RANDOM_ITEMS; k++)
         pending_hsv.push_back(random_hsv());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_hsv.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_rgb.size() != 0)
         @(posedge clock);
      repeat (NUM_STAGES + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #1000000;
      $display("Timeout: %0d transactions accepted, %0d results received",
               accepted_count, received_count);
      $display("Regression FAIL");
      $finish;
   end

endmodule
